/* rtl/core/fixed_block_pool_allocator_assert.svh */
// assertion macros for the fixed block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// condition that holds at every edge out of reset
`define FBPA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/fbpa_pkg.sv */
// shared types, constants and functions of the fixed block pool allocator
package fbpa_pkg;

	localparam int KIND_W      = 2;
	localparam int OFS_W       = 23;
	localparam int BOFS_W      = 22;
	localparam int CNT_W       = 11;
	localparam int SIZE_W      = 13;
	localparam int STAT_W      = 2;
	localparam int CFG_W       = 13;
	localparam int REG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_FIELD_W = STAT_W + BOFS_W + CNT_W + CNT_W;
	localparam int OUT_TDATA_W = 48;

	localparam int DEF_MAX_BLOCKS  = 1024;
	localparam int MAX_BLOCK_BYTES = 4096;

	localparam logic [SIZE_W-1:0] MIN_BLOCK_BYTES = 13'd8;
	localparam logic [SIZE_W-1:0] RST_BLOCK_BYTES = 13'd64;
	localparam logic [CNT_W-1:0]  RST_BLOCKS      = 11'd1024;

	localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES    = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_BLOCKS_IN_POOL = 1'd1;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_UNALIGNED = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} fbpa_state_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s < MIN_BLOCK_BYTES) begin
			r = MIN_BLOCK_BYTES;
		end else if (32'(s) > MAX_BLOCK_BYTES) begin
			r = SIZE_W'(MAX_BLOCK_BYTES);
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
			input int unsigned max_blocks);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (32'(c) > max_blocks) begin
			r = CNT_W'(max_blocks);
		end
		return r;
	endfunction

endpackage

/* rtl/core/fixed_block_pool_allocator.sv */
// top level of the fixed block pool allocator
// Fixed-block pool allocator with a LIFO free list kept in a synchronous ram, one link word
// per block. One request is worked at a time; a new request is taken as soon as the
// previous result sits in the output register. Allocate, reinitialize, unknown kinds and a
// free whose offset is out of range go from acceptance through the execute state (ram read
// and update) and the done state (result load) before the next request is taken in idle.
// Any other free has a divide state between execute and done: the offset is divided by
// the block size in a restoring divider that makes one quotient bit per cycle over 22 bits.
// A result that is not taken holds the next request in the sequencer and stalls the input.
// Register writes take effect on the pool only at reset and on a reinitialize request. The
// link ram needs no clearing.
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// free_offset, zero pad
	input  logic [fbpa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// kind
	input  logic [fbpa_pkg::KIND_W-1:0]        s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// status, block_offset, blocks in use, capacity, zero pad
	output logic [fbpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [fbpa_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]         cfg_data
);
	import fbpa_pkg::*;

	localparam int IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int XW    = (IW > CNT_W) ? IW : CNT_W;
	localparam int LW    = IW + 1;
	localparam int LIM_W = SIZE_W + CNT_W;
	localparam int PW    = IW + SIZE_W;
	localparam logic [SIZE_W-1:0] GEO_SIZE_RST  = clamp_size(RST_BLOCK_BYTES);
	localparam logic [CNT_W-1:0]  GEO_COUNT_RST = clamp_count(RST_BLOCKS, MAX_BLOCKS);
	localparam logic [LIM_W-1:0]  LIMIT_RST     =
		LIM_W'(GEO_SIZE_RST) * LIM_W'(GEO_COUNT_RST);

	fbpa_state_t state_q, state_d;

	logic [SIZE_W-1:0] block_bytes_q;
	logic [CNT_W-1:0]  blocks_in_pool_q;
	logic [SIZE_W-1:0] geo_size_q;
	logic [CNT_W-1:0]  geo_count_q;
	logic [LIM_W-1:0]  limit_q;
	logic [IW-1:0]     head_q;
	logic              empty_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  in_use_q;
	logic              out_valid_q;

	logic [KIND_W-1:0]      kind_q;
	logic [OFS_W-1:0]       ofs_q;
	logic [STAT_W-1:0]      status_q;
	logic [BOFS_W-1:0]      bofs_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              in_fire;
	logic              ram_re;
	logic              div_start;
	logic              out_load;
	logic              out_of_range;
	logic [SIZE_W-1:0] size_cl;
	logic [CNT_W-1:0]  count_cl;
	logic [CNT_W-1:0]  fresh_dec;
	logic [XW-1:0]     fresh_x;
	logic [IW-1:0]     alloc_idx;
	logic              alloc_ok;
	logic [PW-1:0]     alloc_prod;
	logic              push;

	logic [LW-1:0]     rd_data;
	logic              div_done;
	logic [BOFS_W-1:0] div_quo;
	logic [SIZE_W-1:0] div_rem;
	logic [IW-1:0]     div_idx;

	always_comb begin
		in_fire      = s_axis_tvalid && s_axis_tready;
		out_of_range = ofs_q[OFS_W-1] || (LIM_W'(ofs_q[BOFS_W-1:0]) >= limit_q);
		size_cl      = clamp_size(block_bytes_q);
		count_cl     = clamp_count(blocks_in_pool_q, MAX_BLOCKS);
		fresh_dec    = fresh_q - CNT_W'(1);
		fresh_x      = XW'(fresh_dec);
		alloc_ok     = !empty_q || (fresh_q != '0);
		alloc_idx    = !empty_q ? head_q : fresh_x[IW-1:0];
		alloc_prod   = PW'(alloc_idx) * PW'(geo_size_q);
		div_idx      = div_quo[IW-1:0];
		push         = (state_q == ST_DIV) && div_done && (div_rem == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_EXEC;
			ST_EXEC: begin
				if (kind_q == KIND_FREE && !out_of_range) state_d = ST_DIV;
				else state_d = ST_DONE;
			end
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		ram_re        = s_axis_tvalid && (state_q == ST_IDLE);
		div_start     = (state_q == ST_EXEC) && (kind_q == KIND_FREE) && !out_of_range;
		out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			block_bytes_q    <= RST_BLOCK_BYTES;
			blocks_in_pool_q <= RST_BLOCKS;
			geo_size_q       <= GEO_SIZE_RST;
			geo_count_q      <= GEO_COUNT_RST;
			limit_q          <= LIMIT_RST;
			head_q           <= '0;
			empty_q          <= 1'b1;
			fresh_q          <= GEO_COUNT_RST;
			in_use_q         <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BLOCK_BYTES:    block_bytes_q    <= cfg_data[SIZE_W-1:0];
					REG_BLOCKS_IN_POOL: blocks_in_pool_q <= cfg_data[CNT_W-1:0];
				endcase
			end
			if (state_q == ST_EXEC) begin
				unique case (kind_q)
					KIND_ALLOC: begin
						if (alloc_ok) begin
							if (!empty_q) begin
								head_q  <= rd_data[IW-1:0];
								empty_q <= rd_data[IW];
							end else begin
								fresh_q <= fresh_dec;
							end
							if (in_use_q < geo_count_q) in_use_q <= in_use_q + CNT_W'(1);
						end
					end
					KIND_REINIT: begin
						geo_size_q  <= size_cl;
						geo_count_q <= count_cl;
						limit_q     <= LIM_W'(size_cl) * LIM_W'(count_cl);
						head_q      <= '0;
						empty_q     <= 1'b1;
						fresh_q     <= count_cl;
						in_use_q    <= '0;
					end
					default: begin
					end
				endcase
			end
			if (push) begin
				head_q  <= div_idx;
				empty_q <= 1'b0;
				if (in_use_q != '0) in_use_q <= in_use_q - CNT_W'(1);
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= s_axis_tuser;
			ofs_q  <= s_axis_tdata[OFS_W-1:0];
		end
		if (state_q == ST_EXEC) begin
			status_q <= STAT_OK;
			bofs_q   <= '0;
			if (kind_q == KIND_ALLOC) begin
				if (alloc_ok) bofs_q <= BOFS_W'(alloc_prod);
				else status_q <= STAT_EMPTY;
			end else if (kind_q == KIND_FREE && out_of_range) begin
				status_q <= STAT_RANGE;
			end
		end
		if (state_q == ST_DIV && div_done && div_rem != '0) begin
			status_q <= STAT_UNALIGNED;
		end
		if (out_load) begin
			out_data_q <= OUT_TDATA_W'({geo_count_q, in_use_q, bofs_q, status_q});
		end
	end

	fbpa_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (push),
		.waddr (div_idx),
		.wdata ({empty_q, head_q}),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (rd_data)
	);

	fbpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (ofs_q[BOFS_W-1:0]),
		.divisor   (geo_size_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`FBPA_ASSERT_ALWAYS(a_in_use_le_cap, in_use_q <= geo_count_q, "allocated count above capacity")
	`FBPA_ASSERT_ALWAYS(a_fresh_le_cap, fresh_q <= geo_count_q, "untouched blocks above capacity")
	`FBPA_ASSERT_NEXT(a_div_to_done, (state_q == ST_DIV) && div_done, state_q == ST_DONE,
		"divider result not taken")

endmodule

/* rtl/core/fbpa_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/fbpa_div.sv */
// restoring divider, one quotient bit per cycle, for offset by block size
module fbpa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fbpa_pkg::BOFS_W-1:0]   dividend,
	input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
	output logic                          done,
	output logic [fbpa_pkg::BOFS_W-1:0]   quotient,
	output logic [fbpa_pkg::SIZE_W-1:0]   remainder
);
	import fbpa_pkg::*;

	localparam int STEP_W = $clog2(BOFS_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [BOFS_W-1:0] quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dvs_q;

	logic [SIZE_W:0]   trial;
	logic [SIZE_W+1:0] diff;
	logic              ge;
	logic [SIZE_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[BOFS_W-1]};
		diff     = {1'b0, trial} - {2'b00, dvs_q};
		ge       = !diff[SIZE_W+1];
		rem_next = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(BOFS_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[BOFS_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* dv/tb.sv */
// self-checking stream testbench for the fixed block pool allocator
`timescale 1ns / 100ps

module tb;
	import fbpa_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam int POOL_DEPTH = DEF_MAX_BLOCKS;
	localparam int IDX_W = $clog2(POOL_DEPTH);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFS_W-1:0]  offset;
	} pool_req_t;

	typedef struct packed {
		logic [CNT_W-1:0]  capacity;
		logic [CNT_W-1:0]  used;
		logic [BOFS_W-1:0] offset;
		logic [STAT_W-1:0] status;
	} pool_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]      s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	pool_req_t   pending_reqs[$];
	pool_reply_t expected_replies[$];
	int unsigned replies_owed = 0;
	int unsigned fail_count = 0;
	int unsigned tx_gap_max = 16;
	int unsigned rx_gap_max = 16;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_hold = 0;
	bit          word_in = 1'b0;
	bit          word_out = 1'b0;

	// shadow pool
	logic [SIZE_W-1:0] reg_bytes;
	logic [CNT_W-1:0]  reg_blocks;
	logic [SIZE_W-1:0] pool_size;
	logic [CNT_W-1:0]  pool_count;
	logic [IDX_W-1:0]  link_next [POOL_DEPTH];
	bit                link_last [POOL_DEPTH];
	logic [IDX_W-1:0]  list_top;
	bit                list_none;
	logic [CNT_W-1:0]  fresh_left;
	logic [CNT_W-1:0]  blocks_used;

	fixed_block_pool_allocator #(
		.MAX_BLOCKS(POOL_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void reload_pool();
		pool_size = reg_bytes;
		if (reg_bytes < MIN_BLOCK_BYTES) begin
			pool_size = MIN_BLOCK_BYTES;
		end else if (int'(reg_bytes) > MAX_BLOCK_BYTES) begin
			pool_size = SIZE_W'(MAX_BLOCK_BYTES);
		end
		pool_count = reg_blocks;
		if (reg_blocks == '0) begin
			pool_count = CNT_W'(1);
		end else if (int'(reg_blocks) > POOL_DEPTH) begin
			pool_count = CNT_W'(POOL_DEPTH);
		end
		list_top = '0;
		list_none = 1'b1;
		fresh_left = pool_count;
		blocks_used = '0;
	endfunction

	function automatic pool_reply_t serve_request(input pool_req_t req);
		pool_reply_t rep;
		int unsigned blk;
		int unsigned ofs;
		int unsigned span;
		bit          got;
		rep = '0;
		rep.status = STAT_OK;
		got = 1'b0;
		blk = 0;
		ofs = 32'(req.offset);
		span = 32'(pool_size) * 32'(pool_count);
		case (req.kind)
			KIND_ALLOC: begin
				if (!list_none) begin
					blk = 32'(list_top);
					list_none = link_last[list_top];
					list_top = link_next[list_top];
					got = 1'b1;
				end else if (fresh_left != '0) begin
					fresh_left--;
					blk = 32'(fresh_left);
					got = 1'b1;
				end
				if (got) begin
					if (blocks_used < pool_count) blocks_used++;
					rep.offset = BOFS_W'(blk * 32'(pool_size));
				end else begin
					rep.status = STAT_EMPTY;
				end
			end
			KIND_FREE: begin
				if (req.offset[OFS_W-1] || ofs >= span) begin
					rep.status = STAT_RANGE;
				end else if (ofs % 32'(pool_size) != 0) begin
					rep.status = STAT_UNALIGNED;
				end else begin
					blk = ofs / 32'(pool_size);
					link_next[IDX_W'(blk)] = list_top;
					link_last[IDX_W'(blk)] = list_none;
					list_top = IDX_W'(blk);
					list_none = 1'b0;
					if (blocks_used != '0) blocks_used--;
				end
			end
			KIND_REINIT: begin
				reload_pool();
			end
			default: ;
		endcase
		rep.used = blocks_used;
		rep.capacity = pool_count;
		return rep;
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", field, want, seen);
			fail_count++;
		end
	endfunction

	function automatic void push_request(input logic [KIND_W-1:0] kind, input int ofs);
		pending_reqs.push_back(pool_req_t'{kind, OFS_W'(ofs)});
		replies_owed++;
	endfunction

	function automatic void add_random_request();
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(0, 99);
		span = 32'(pool_size) * 32'(pool_count);
		if (pick < 45) begin
			push_request(KIND_ALLOC, $urandom);
		end else if (pick < 80) begin
			push_request(KIND_FREE, $urandom_range(0, pool_count - 1) * pool_size);
		end else if (pick < 85) begin
			push_request(KIND_FREE, $urandom_range(0, span - 1));
		end else if (pick < 90) begin
			push_request(KIND_FREE, $urandom);
		end else if (pick < 94) begin
			push_request(KIND_FREE, pick[0] ? span : -$urandom_range(1, 4194304));
		end else if (pick < 97) begin
			push_request(KIND_NONE, $urandom);
		end else begin
			push_request(KIND_REINIT, $urandom);
		end
	endfunction

	// request driver
	always @(negedge clk) begin : drive
		pool_req_t req;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || word_in) begin
			word_in = 1'b0;
			if (tx_wait > 0) begin
				tx_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= IN_TDATA_W'(req.offset);
				s_axis_tuser <= req.kind;
				tx_wait = $urandom_range(0, tx_gap_max);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (word_out) begin
			word_out = 1'b0;
			rx_wait = $urandom_range(0, rx_gap_max);
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			if (m_axis_tvalid) rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// word monitor and checker
	always @(posedge clk) begin : watch
		pool_reply_t seen;
		pool_reply_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_replies.push_back(serve_request(
					pool_req_t'{s_axis_tuser, s_axis_tdata[OFS_W-1:0]}));
				word_in = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				word_out = 1'b1;
				seen = m_axis_tdata[OUT_FIELD_W-1:0];
				if (expected_replies.size() == 0) begin
					$error("result word with nothing expected: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					if (replies_owed > 0) replies_owed--;
					check_field("status", 32'(want.status), 32'(seen.status));
					check_field("block_offset", 32'(want.offset), 32'(seen.offset));
					check_field("blocks_in_use", 32'(want.used), 32'(seen.used));
					check_field("capacity", 32'(want.capacity), 32'(seen.capacity));
				end
			end
		end
	end

	task automatic wait_idle();
		do @(negedge clk); while (replies_owed != 0 || pending_reqs.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_BLOCK_BYTES) begin
			reg_bytes = val;
		end else begin
			reg_blocks = val[CNT_W-1:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup_pool(input logic [CFG_W-1:0] bytes, input logic [CFG_W-1:0] blocks);
		write_reg(REG_BLOCK_BYTES, bytes);
		write_reg(REG_BLOCKS_IN_POOL, blocks);
		push_request(KIND_REINIT, 0);
		wait_idle();
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] bytes, input logic [CFG_W-1:0] blocks,
			input int unsigned count, input int unsigned tx_max, input int unsigned rx_max,
			input int unsigned hold);
		setup_pool(bytes, blocks);
		@(posedge clk);
		tx_gap_max = tx_max;
		rx_gap_max = rx_max;
		rx_hold = hold;
		repeat (count) add_random_request();
		wait_idle();
	endtask

	initial begin
		reg_bytes = RST_BLOCK_BYTES;
		reg_blocks = RST_BLOCKS;
		reload_pool();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry: top fresh block, bad offsets, unknown kind
		push_request(KIND_ALLOC, 0);
		push_request(KIND_ALLOC, -1);
		push_request(KIND_FREE, 1023 * 64);
		push_request(KIND_FREE, -1);
		push_request(KIND_FREE, -4194304);
		push_request(KIND_FREE, 4194303);
		push_request(KIND_FREE, 65536);
		push_request(KIND_FREE, 65535);
		push_request(KIND_FREE, 0);
		push_request(KIND_NONE, 0);
		push_request(KIND_ALLOC, 0);
		push_request(KIND_REINIT, 0);
		wait_idle();

		// register write alone leaves the pool as it is
		write_reg(REG_BLOCK_BYTES, 13'd16);
		push_request(KIND_ALLOC, 0);
		wait_idle();

		// clamped low: one block of 8 bytes, empty pool and double free
		setup_pool(13'd0, 13'd0);
		push_request(KIND_ALLOC, 0);
		push_request(KIND_ALLOC, 0);
		push_request(KIND_FREE, 0);
		push_request(KIND_FREE, 0);
		push_request(KIND_ALLOC, 0);
		push_request(KIND_ALLOC, 0);
		push_request(KIND_ALLOC, 0);
		push_request(KIND_FREE, 8);
		wait_idle();

		// clamped high: 1024 blocks of 4096 bytes
		setup_pool(13'h1FFF, 13'h1FFF);
		push_request(KIND_ALLOC, 0);
		push_request(KIND_FREE, 1023 * 4096);
		push_request(KIND_FREE, 4194303);
		push_request(KIND_ALLOC, 0);
		wait_idle();

		run_phase(13'd8, 13'd4, 120, 16, 16, 0);
		run_phase(13'd4096, 13'd1024, 110, 0, 0, 0);
		run_phase(13'd24, 13'd7, 110, 16, 0, 0);
		run_phase(13'd100, 13'd300, 120, 0, 16, 400);
		run_phase(13'd0, 13'd2047, 100, 16, 16, 0);
		run_phase(13'd8191, 13'd0, 60, 4, 8, 0);
		run_phase(13'd4000, 13'd33, 100, 16, 16, 0);

		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("fixed_block_pool_allocator verification clean");
		end else begin
			$display("fixed_block_pool_allocator verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("fixed_block_pool_allocator verification failed");
		$finish;
	end

endmodule
